[src/quadratic_root_solver_macros.svh]
// Assertion macros for the quadratic root solver.
// Included by the modules that check their own logic; no other dependencies.
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH
`ifndef SYNTH
`define QRS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define QRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define QRS_ASSERT(lbl, clk, rst_n, prop, msg)
`define QRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[src/qrs_pkg.sv]
// Shared types and constants for the quadratic root solver.
// No dependencies; imported by every module of the block.
package qrs_pkg;

  typedef enum logic [2:0] {
    KIND_TWO_REAL = 3'd0,
    KIND_DOUBLE   = 3'd1,
    KIND_COMPLEX  = 3'd2,
    KIND_LINEAR   = 3'd3,
    KIND_NONE     = 3'd4
  } root_kind_t;

  localparam int SQ_STAGES  = 25;
  localparam int DIV_STAGES = 32;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // One classified transaction as it waits between front and back
  typedef struct packed {
    root_kind_t         kind;
    logic [32:0]        dmag;  // |b*b - 4ac|, Q16.16 raw
    logic signed [15:0] den;   // divisor: a, b, or one
    logic signed [32:0] base;  // -b*2^15, or -c*2^16 for the linear case
  } q_item_t;

endpackage

[src/qrs_front.sv]
// Front end: accepts coefficients, forms the discriminant and classifies.
// Depends on qrs_pkg; pushes into the queue.
module qrs_front import qrs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_coef_a,
  input  logic signed [15:0] in_coef_b,
  input  logic signed [15:0] in_coef_c,
  output logic               push,
  output q_item_t            push_item,
  input  logic               q_full,
  input  logic               q_pop
);

  logic               v_r;
  logic signed [15:0] a_r, b_r, c_r;
  logic signed [31:0] bb_r, ac_r;
  logic               can_push;
  logic               load;
  logic signed [33:0] disc;
  logic        [33:0] dneg;
  logic        [32:0] bsh, csh;

  assign can_push = !q_full || q_pop;
  assign in_stall = v_r && !can_push;
  assign push     = v_r && can_push;
  assign load     = !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (load) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      a_r  <= in_coef_a;
      b_r  <= in_coef_b;
      c_r  <= in_coef_c;
      bb_r <= in_coef_b * in_coef_b;
      ac_r <= in_coef_a * in_coef_c;
    end
  end

  assign disc = $signed({{2{bb_r[31]}}, bb_r} - {ac_r, 2'b00});
  assign dneg = -disc;
  assign bsh  = {{2{b_r[15]}}, b_r, 15'b0};
  assign csh  = {c_r[15], c_r, 16'b0};

  always_comb begin
    push_item.dmag = disc[33] ? dneg[32:0] : disc[32:0];
    push_item.den  = a_r;
    push_item.base = $signed(-bsh);
    if (a_r == 16'sd0) begin
      push_item.dmag = '0;
      if (b_r != 16'sd0) begin
        push_item.kind = KIND_LINEAR;
        push_item.den  = b_r;
        push_item.base = $signed(-csh);
      end else begin
        // keep the divider away from zero; both numerators are zero
        push_item.kind = KIND_NONE;
        push_item.den  = 16'sd1;
        push_item.base = '0;
      end
    end else if (disc[33]) begin
      push_item.kind = KIND_COMPLEX;
    end else if (disc == 34'sd0) begin
      push_item.kind = KIND_DOUBLE;
    end else begin
      push_item.kind = KIND_TWO_REAL;
    end
  end

endmodule

[src/qrs_queue.sv]
// Short transaction queue between front and back.
// Depends on qrs_pkg and the assertion macro header.
`include "quadratic_root_solver_macros.svh"
module qrs_queue import qrs_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t wr_item,
  input  logic    pop,
  output q_item_t rd_item,
  output logic    empty,
  output logic    full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t         mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  assign empty   = (cnt_r == CW'(0));
  assign full    = (cnt_r == CW'(DEPTH));
  assign rd_item = mem_r[rd_ptr_r];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_item;
  end

  `QRS_ASSERT_IMP(a_no_overrun, clk, rst_n, push, !full || pop, "queue overrun")
  `QRS_ASSERT_IMP(a_no_underrun, clk, rst_n, pop, !empty, "queue underrun")
  `QRS_ASSERT_IMP(a_fill, clk, rst_n, push && !pop, ##1 cnt_r == $past(cnt_r) + 1'b1,
    "queue count did not advance on push")
  `QRS_ASSERT(a_ptr_gap, clk, rst_n,
    (wr_ptr_r == rd_ptr_r) == (empty || full), "queue pointers disagree with count")

endmodule

[src/qrs_sqrt.sv]
// Pipelined integer square root, one result bit per stage, with item context.
// Depends on qrs_pkg.
module qrs_sqrt import qrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  q_item_t     in_item,
  output logic        out_valid,
  output logic [24:0] out_root,
  output q_item_t     out_item
);

  logic [26:0] rem_r  [SQ_STAGES];
  logic [24:0] root_r [SQ_STAGES];
  logic [49:0] n_r    [SQ_STAGES];
  q_item_t     ctx_r  [SQ_STAGES];
  logic        v_r    [SQ_STAGES];

  logic [26:0] rem_nxt  [SQ_STAGES];
  logic [24:0] root_nxt [SQ_STAGES];
  logic [49:0] n_nxt    [SQ_STAGES];

  always_comb begin
    for (int i = 0; i < SQ_STAGES; i++) begin
      logic [26:0] rs;
      logic [24:0] qs;
      logic [49:0] ns;
      logic [28:0] r4, t;
      logic        ge;
      if (i == 0) begin
        rs = '0;
        qs = '0;
        ns = {1'b0, in_item.dmag, 16'b0};
      end else begin
        rs = rem_r[i-1];
        qs = root_r[i-1];
        ns = n_r[i-1];
      end
      r4 = {rs, ns[49:48]};
      t  = {2'b00, qs, 2'b01};
      ge = (r4 >= t);
      rem_nxt[i]  = ge ? 27'(r4 - t) : r4[26:0];
      root_nxt[i] = {qs[23:0], ge};
      n_nxt[i]    = {ns[47:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQ_STAGES; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < SQ_STAGES; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SQ_STAGES; i++) begin
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
        n_r[i]    <= n_nxt[i];
      end
      ctx_r[0] <= in_item;
      for (int i = 1; i < SQ_STAGES; i++) ctx_r[i] <= ctx_r[i-1];
    end
  end

  assign out_valid = v_r[SQ_STAGES-1];
  assign out_root  = root_r[SQ_STAGES-1];
  assign out_item  = ctx_r[SQ_STAGES-1];

endmodule

[src/qrs_div.sv]
// Pipelined restoring divider, unsigned 32 by 16 bits, one quotient bit per stage.
// Depends on qrs_pkg for the stage count.
module qrs_div import qrs_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num_mag,
  input  logic [15:0] den_mag,
  output logic [31:0] quo
);

  logic [15:0] rem_r [DIV_STAGES];
  logic [31:0] nq_r  [DIV_STAGES];
  logic [15:0] den_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        logic [15:0] rs, ds;
        logic [31:0] qs;
        logic [16:0] sh;
        logic        ge;
        if (i == 0) begin
          rs = '0;
          qs = num_mag;
          ds = den_mag;
        end else begin
          rs = rem_r[i-1];
          qs = nq_r[i-1];
          ds = den_r[i-1];
        end
        sh = {rs, qs[31]};
        ge = (sh >= {1'b0, ds});
        rem_r[i] <= ge ? 16'(sh - {1'b0, ds}) : sh[15:0];
        nq_r[i]  <= {qs[30:0], ge};
        den_r[i] <= ds;
      end
    end
  end

  assign quo = nq_r[DIV_STAGES-1];

endmodule

[src/qrs_back.sv]
// Back end: square root, numerator set-up, two dividers, saturation, output register.
// Depends on qrs_pkg, qrs_sqrt, qrs_div and the assertion macro header.
`include "quadratic_root_solver_macros.svh"
module qrs_back import qrs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  q_item_t            q_item,
  output logic               q_pop,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [2:0]         out_root_kind,
  output logic signed [31:0] out_first_value,
  output logic signed [31:0] out_second_value,
  output logic               out_overflow
);

  logic               en;
  logic               sq_v;
  logic [24:0]        sq_root;
  q_item_t            sq_item;
  logic signed [32:0] s128, num1, num2, neg1, neg2;
  logic        [15:0] dneg;

  logic               p_v_r, p_s1_r, p_s2_r;
  root_kind_t         p_kind_r;
  logic [31:0]        p_n1_r, p_n2_r;
  logic [15:0]        p_den_r;

  logic               l_v_r    [DIV_STAGES];
  root_kind_t         l_kind_r [DIV_STAGES];
  logic               l_s1_r   [DIV_STAGES];
  logic               l_s2_r   [DIV_STAGES];

  logic [31:0]        q1, q2;
  logic [32:0]        r1, r2;

  logic               out_valid_r, out_ovf_r;
  root_kind_t         out_kind_r;
  logic [31:0]        out_first_r, out_second_r;

  // advance the whole back pipe unless a finished result is held
  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && !q_empty;

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (!q_empty),
    .in_item   (q_item),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_item  (sq_item)
  );

  assign s128 = {1'b0, sq_root, 7'b0};

  always_comb begin
    num1 = sq_item.base;
    case (sq_item.kind)
      KIND_TWO_REAL: begin
        num1 = sq_item.base + s128;
        num2 = sq_item.base - s128;
      end
      KIND_COMPLEX: num2 = s128;
      default:      num2 = '0;
    endcase
  end

  assign neg1 = -num1;
  assign neg2 = -num2;
  assign dneg = -sq_item.den;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_kind_r <= sq_item.kind;
      p_n1_r   <= num1[32] ? neg1[31:0] : num1[31:0];
      p_n2_r   <= num2[32] ? neg2[31:0] : num2[31:0];
      p_den_r  <= sq_item.den[15] ? dneg : sq_item.den;
      p_s1_r   <= num1[32] ^ sq_item.den[15];
      p_s2_r   <= num2[32] ^ sq_item.den[15];
    end
  end

  qrs_div u_div1 (.clk(clk), .en(en), .num_mag(p_n1_r), .den_mag(p_den_r), .quo(q1));
  qrs_div u_div2 (.clk(clk), .en(en), .num_mag(p_n2_r), .den_mag(p_den_r), .quo(q2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STAGES; i++) l_v_r[i] <= 1'b0;
    end else if (en) begin
      l_v_r[0] <= p_v_r;
      for (int i = 1; i < DIV_STAGES; i++) l_v_r[i] <= l_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_kind_r[0] <= p_kind_r;
      l_s1_r[0]   <= p_s1_r;
      l_s2_r[0]   <= p_s2_r;
      for (int i = 1; i < DIV_STAGES; i++) begin
        l_kind_r[i] <= l_kind_r[i-1];
        l_s1_r[i]   <= l_s1_r[i-1];
        l_s2_r[i]   <= l_s2_r[i-1];
      end
    end
  end

  // {saturated, value} from sign and quotient magnitude
  function automatic logic [32:0] sat_val(input logic neg, input logic [31:0] mag);
    logic [31:0] nv;
    nv = ~mag + 32'd1;
    if (!neg) begin
      return mag[31] ? {1'b1, Q_MAX} : {1'b0, mag};
    end else if (mag[31] && (|mag[30:0])) begin
      return {1'b1, Q_MIN};
    end else begin
      return {1'b0, nv};
    end
  endfunction

  assign r1 = sat_val(l_s1_r[DIV_STAGES-1], q1);
  assign r2 = sat_val(l_s2_r[DIV_STAGES-1], q2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= l_v_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_kind_r   <= l_kind_r[DIV_STAGES-1];
      out_first_r  <= r1[31:0];
      out_second_r <= r2[31:0];
      out_ovf_r    <= r1[32] | r2[32];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_root_kind    = out_kind_r;
  assign out_first_value  = $signed(out_first_r);
  assign out_second_value = $signed(out_second_r);
  assign out_overflow     = out_ovf_r;

  `QRS_ASSERT_IMP(a_none_zero, clk, rst_n, out_valid_r && out_kind_r == KIND_NONE,
    out_first_r == '0 && out_second_r == '0 && !out_ovf_r, "no-equation result not zero")
  `QRS_ASSERT_IMP(a_single_zero, clk, rst_n,
    out_valid_r && (out_kind_r == KIND_DOUBLE || out_kind_r == KIND_LINEAR),
    out_second_r == '0, "second value set for a single root")
  `QRS_ASSERT_IMP(a_ovf_sat, clk, rst_n, out_valid_r && out_ovf_r,
    out_first_r == Q_MAX || out_first_r == Q_MIN || out_second_r == Q_MAX ||
    out_second_r == Q_MIN, "overflow flagged without a saturated value")

endmodule

[src/quadratic_root_solver.sv]
// Quadratic root solver: takes a, b, c in signed Q8.8 and returns the roots in Q16.16
// (two real, double, complex pair, linear, or no equation) with a saturation flag.
// One transaction is accepted every cycle while in_stall is low; its result passes
// one front register, one queue slot, a 25-stage square root, one numerator stage,
// a 32-stage divider pair and the output register before being offered. The front end
// keeps accepting while the result side stalls until its QUEUE_DEPTH-entry queue fills.
// Depends on qrs_pkg, qrs_front, qrs_queue and qrs_back.
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_coef_a,
  input  logic signed [15:0] in_coef_b,
  input  logic signed [15:0] in_coef_c,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_root_kind,
  output logic signed [31:0] out_first_value,
  output logic signed [31:0] out_second_value,
  output logic               out_overflow
);

  logic    push, pop, q_empty, q_full;
  q_item_t push_item, rd_item;

  qrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_coef_a (in_coef_a),
    .in_coef_b (in_coef_b),
    .in_coef_c (in_coef_c),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full),
    .q_pop     (pop)
  );

  qrs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (push_item),
    .pop     (pop),
    .rd_item (rd_item),
    .empty   (q_empty),
    .full    (q_full)
  );

  qrs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_item           (rd_item),
    .q_pop            (pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_root_kind    (out_root_kind),
    .out_first_value  (out_first_value),
    .out_second_value (out_second_value),
    .out_overflow     (out_overflow)
  );

endmodule

[tb/sv/tb_quadratic_root_solver.sv]
// Self-checking testbench for quadratic_root_solver: queued coefficient sets are
// driven with random gaps, results are checked against a local root predictor.
// Depends on qrs_pkg and the quadratic_root_solver RTL.
module tb_quadratic_root_solver;
  import qrs_pkg::*;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    bit                 drain;  // wait for every result before offering this one
  } coef_set_t;

  typedef struct {
    root_kind_t         kind;
    logic signed [31:0] first;
    logic signed [31:0] second;
    logic               ovf;
  } roots_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_coef_a = '0;
  logic signed [15:0] in_coef_b = '0;
  logic signed [15:0] in_coef_c = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_root_kind;
  logic signed [31:0] out_first_value;
  logic signed [31:0] out_second_value;
  logic               out_overflow;

  coef_set_t pending_sets[$];
  roots_t    expected_roots[$];
  int        errors = 0;
  int        sent_cnt = 0;
  int        rcvd_cnt = 0;
  int        send_gap = 0;
  int        stall_left = 0;
  bit        hold_done = 1'b0;
  bit        fill_done = 1'b0;

  quadratic_root_solver dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_root_kind(out_root_kind), .out_first_value(out_first_value),
    .out_second_value(out_second_value), .out_overflow(out_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned root_bit;
    root = 0;
    root_bit = 64'd1 << 62;
    while (root_bit > n) root_bit >>= 2;
    while (root_bit != 0) begin
      if (n >= root + root_bit) begin
        n -= root + root_bit;
        root = (root >> 1) + root_bit;
      end else begin
        root >>= 1;
      end
      root_bit >>= 2;
    end
    return root;
  endfunction

  function automatic longint clamp_q16(longint v, ref logic ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic roots_t solve_roots(coef_set_t s);
    roots_t r;
    longint a, b, c, disc, mb, sq;
    logic ovf;
    a = longint'(s.a);
    b = longint'(s.b);
    c = longint'(s.c);
    ovf = 1'b0;
    r.first = '0;
    r.second = '0;
    if (a == 0) begin
      if (b != 0) begin
        r.kind = KIND_LINEAR;
        r.first = 32'(clamp_q16((-c * 65536) / b, ovf));
      end else begin
        r.kind = KIND_NONE;
      end
    end else begin
      disc = b * b - 4 * a * c;
      mb = -b * 256;
      if (disc > 0) begin
        sq = longint'(floor_sqrt(longint'(disc) * 65536));
        r.kind = KIND_TWO_REAL;
        r.first = 32'(clamp_q16(((mb + sq) * 128) / a, ovf));
        r.second = 32'(clamp_q16(((mb - sq) * 128) / a, ovf));
      end else if (disc == 0) begin
        r.kind = KIND_DOUBLE;
        r.first = 32'(clamp_q16((mb * 128) / a, ovf));
      end else begin
        sq = longint'(floor_sqrt(longint'(-disc) * 65536));
        r.kind = KIND_COMPLEX;
        r.first = 32'(clamp_q16((mb * 128) / a, ovf));
        r.second = 32'(clamp_q16((sq * 128) / a, ovf));
      end
    end
    r.ovf = ovf;
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [15:0] pick_coef();
    int r;
    logic [31:0] w;
    r = $urandom_range(0, 19);
    w = $urandom;
    case (r)
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return 16'sd1;
      4: return -16'sd1;
      5: return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
      default: return w[15:0];
    endcase
  endfunction

  task automatic queue_set(logic signed [15:0] a, logic signed [15:0] b,
                           logic signed [15:0] c, bit drain);
    coef_set_t s;
    s.a = a;
    s.b = b;
    s.c = c;
    s.drain = drain;
    pending_sets.push_back(s);
  endtask

  // Driver: advance on each accepted transaction, hold the payload while stalled
  always @(posedge clk) begin
    coef_set_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s = pending_sets.pop_front();
        expected_roots.push_back(solve_roots(s));
        sent_cnt++;
        send_gap = ((sent_cnt / 200) % 4 == 1) ? 0 : pick_gap();
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_sets.size() > 0 &&
                     (!pending_sets[0].drain || expected_roots.size() == 0)) begin
          in_valid  <= 1'b1;
          in_coef_a <= pending_sets[0].a;
          in_coef_b <= pending_sets[0].b;
          in_coef_c <= pending_sets[0].c;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction
  always @(posedge clk) begin
    roots_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        rcvd_cnt++;
        if (expected_roots.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result kind=%0d", out_root_kind);
        end else begin
          e = expected_roots.pop_front();
          if (out_root_kind !== e.kind || out_first_value !== e.first ||
              out_second_value !== e.second || out_overflow !== e.ovf) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch #%0d: exp kind=%0d x1=%h x2=%h ovf=%b, ",
                        "got kind=%0d x1=%h x2=%h ovf=%b"},
                       rcvd_cnt, e.kind, e.first, e.second, e.ovf, out_root_kind,
                       out_first_value, out_second_value, out_overflow);
          end
        end
      end
      // Long hold-off once, so the block fills and stalls its input
      if (!hold_done && rcvd_cnt == 500) begin
        hold_done = 1'b1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ((rcvd_cnt / 200) % 4 == 3) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin
    int r;
    int m;
    logic signed [15:0] a;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: no equation, linear with saturation, each root kind, extremes
    queue_set(16'sd0, 16'sd0, 16'sd0, 1'b0);
    queue_set(16'sd0, 16'sd0, 16'sh7fff, 1'b0);
    queue_set(16'sd0, 16'sd256, -16'sd512, 1'b0);
    queue_set(16'sd0, 16'sd1, 16'sh7fff, 1'b0);
    queue_set(16'sd0, -16'sd1, 16'sh8000, 1'b0);
    queue_set(16'sd0, 16'sh8000, 16'sh7fff, 1'b0);
    queue_set(16'sd256, -16'sd768, 16'sd512, 1'b0);
    queue_set(16'sd256, -16'sd512, 16'sd256, 1'b0);
    queue_set(-16'sd256, 16'sd512, -16'sd256, 1'b0);
    queue_set(16'sd256, 16'sd0, 16'sd256, 1'b0);
    queue_set(-16'sd256, 16'sd0, -16'sd256, 1'b0);
    queue_set(-16'sd256, 16'sd128, -16'sd512, 1'b0);
    queue_set(16'sd1, 16'sh7fff, 16'sh8000, 1'b0);
    queue_set(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    queue_set(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    queue_set(16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0);
    queue_set(16'sd1, 16'sh8000, 16'sd0, 1'b0);
    queue_set(16'sd1, 16'sd0, 16'sd1, 1'b0);
    queue_set(16'sd1, 16'sd0, -16'sd1, 1'b0);
    queue_set(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
    queue_set(-16'sd1, 16'sd0, 16'sh7fff, 1'b0);
    queue_set(16'shffff, 16'shffff, 16'shffff, 1'b0);
    for (int i = 0; i < 1500; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        queue_set(16'sd0, pick_coef(), pick_coef(), i == 800);
      end else if (r < 15) begin
        // double root: b = 2am, c = am^2
        a = $signed(16'($urandom_range(1, 64)));
        if ($urandom_range(0, 1)) a = -a;
        m = $urandom_range(0, 40) - 20;
        queue_set(a, 16'(2 * a * m), 16'(a * m * m), i == 800);
      end else begin
        queue_set(pick_coef(), pick_coef(), pick_coef(), i == 800 || i == 0);
      end
    end
    fill_done = 1'b1;
    wait (pending_sets.size() == 0 && !in_valid);
    wait (expected_roots.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_roots.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/qrs_pkg.sv
src/qrs_front.sv
src/qrs_queue.sv
src/qrs_sqrt.sv
src/qrs_div.sv
src/qrs_back.sv
src/quadratic_root_solver.sv
tb/sv/tb_quadratic_root_solver.sv
